>>> rtl/lfps_pkg.sv
// Shared types, constants and helper functions of the line-follower steering block.
package lfps_pkg;

	// Field widths of the sensor and steering beats.
	localparam int PIN_W   = 8;
	localparam int SPEED_W = 8;
	localparam int EDGE_W  = 2;
	localparam int ERR_W   = 6;
	localparam int DIFF_W  = ERR_W + 1;

	// Gains are unsigned Q4.12.
	localparam int GAIN_W    = 16;
	localparam int FRAC_BITS = 12;

	// Configuration port geometry.
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam int APB_ADDR_W = REG_IDX_W + 2;

	// Register indexes on the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP  = 2'd0,
		REG_INTEG = 2'd1,
		REG_DERIV = 2'd2
	} reg_idx_t;

	// Gain values after reset (0.8, 0.01 and 0.3 in Q4.12).
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd3277;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd41;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd1229;

	// Sticky edge flag codes.
	localparam logic signed [EDGE_W-1:0] EDGE_NONE = 2'sb00;
	localparam logic signed [EDGE_W-1:0] EDGE_FALL = 2'sb01;
	localparam logic signed [EDGE_W-1:0] EDGE_RISE = 2'sb11;

	// Motor speed limits.
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;

	// Position weights of the outer to inner sensor pairs.
	localparam int NUM_PAIRS = PIN_W / 2;
	typedef logic [4:0] weight_t;
	localparam weight_t PAIR_WEIGHT [NUM_PAIRS] = '{5'd7, 5'd5, 5'd3, 5'd1};

	// Weighted position error: right-hand sensors count positive, left-hand negative.
	function automatic logic signed [ERR_W-1:0] position_of(input logic [PIN_W-1:0] s);
		logic [ERR_W-2:0] pos;
		logic [ERR_W-2:0] neg;
		pos = '0;
		neg = '0;
		for (int k = 0; k < NUM_PAIRS; k++) begin
			if (s[PIN_W-1-k]) begin
				pos = pos + PAIR_WEIGHT[k];
			end
			if (s[k]) begin
				neg = neg + PAIR_WEIGHT[k];
			end
		end
		return $signed({1'b0, pos}) - $signed({1'b0, neg});
	endfunction

endpackage

>>> rtl/lfps_in_if.sv
// Sensor channel: one beat carries the raw line pins and the base speed.
interface lfps_in_if;
	import lfps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [PIN_W-1:0]          raw_pins;
	logic signed [SPEED_W-1:0] base_speed;

	modport source (output valid, output raw_pins, output base_speed, input ready);
	modport sink   (input valid, input raw_pins, input base_speed, output ready);
endinterface

>>> rtl/lfps_out_if.sv
// Steering channel: one beat carries the motor speeds and the sensor status.
interface lfps_out_if;
	import lfps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic signed [EDGE_W-1:0]  edge_mark;
	logic [PIN_W-1:0]          line_bits;
	logic signed [ERR_W-1:0]   position_error;

	modport source (
		output valid, output left_speed, output right_speed, output edge_mark,
		output line_bits, output position_error, input ready
	);
	modport sink (
		input valid, input left_speed, input right_speed, input edge_mark,
		input line_bits, input position_error, output ready
	);
endinterface

>>> rtl/line_follower_pid_steering.sv
// Line-follower PID steering controller, top level.
//
// Usage: every sensor beat (raw active-low pins, base speed) produces exactly one
// steering beat (left and right speed, edge flag, inverted pins, position error).
// The gains are written through the APB port at addresses 0x0, 0x4 and 0x8
// while no beat is in flight; pready is always high and reads return the gain.
//
// The accepted beat passes the operand, product and output registers before
// steer.valid rises. Throughput is one beat per cycle while the steering side
// does not stall: the controller state (previous pins, edge flag, integral and
// last error) is updated at the accepting edge, so the next beat sees it at once.
// The three stages are the operand register, the product register (three
// multipliers, the widest 17 x SUM_WIDTH bits) and the output register (sum,
// truncation toward zero and clamp).
//
// Each stage advances when it is empty or the stage behind it moves, so sensor
// beats are still taken while a finished steering beat waits, until all three
// stages are full. A stalled steering beat holds its value.
// Reset clears the state and the stage valid bits and restores the default gains.
module line_follower_pid_steering #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lfps_in_if.sink                          sensor,
	lfps_out_if.source                       steer,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lfps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lfps_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import lfps_pkg::*;

	localparam int P_W   = GAIN_W + 1 + ERR_W;
	localparam int I_W   = GAIN_W + 1 + SUM_WIDTH;
	localparam int D_W   = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W = I_W + 3;
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam int TRUNC_BIAS = (2 ** FRAC_BITS) - 1;

	// Gain registers.
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] integ_gain_q;
	logic [GAIN_W-1:0] deriv_gain_q;
	reg_idx_t          reg_idx;

	// Controller state.
	logic [PIN_W-1:0]            prev_states_q;
	logic signed [EDGE_W-1:0]    edge_state_q;
	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [ERR_W-1:0]     prior_error_q;

	// Next-state values of the beat on the sensor channel.
	logic [PIN_W-1:0]            line_now;
	logic signed [EDGE_W-1:0]    edge_next;
	logic signed [ERR_W-1:0]     err_now;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [DIFF_W-1:0]    diff_now;

	// Stage handshake.
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic in_fire;

	// Stage 1 operands.
	logic signed [SPEED_W-1:0]   base_s1;
	logic [PIN_W-1:0]            bits_s1;
	logic signed [EDGE_W-1:0]    edge_s1;
	logic signed [ERR_W-1:0]     err_s1;
	logic signed [DIFF_W-1:0]    diff_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;

	// Stage 2 products.
	logic signed [GAIN_W:0]      kp_x, ki_x, kd_x;
	logic signed [P_W-1:0]       prod_p, prod_p_s2;
	logic signed [I_W-1:0]       prod_i, prod_i_s2;
	logic signed [D_W-1:0]       prod_d, prod_d_s2;
	logic signed [SPEED_W-1:0]   base_s2;
	logic [PIN_W-1:0]            bits_s2;
	logic signed [EDGE_W-1:0]    edge_s2;
	logic signed [ERR_W-1:0]     err_s2;

	// Stage 3 arithmetic and output register.
	logic signed [ACC_W-1:0]     base_x, corr, acc_l, acc_r, q_l, q_r;
	logic signed [SPEED_W-1:0]   left_c, right_c;
	logic signed [SPEED_W-1:0]   left_s3, right_s3;
	logic signed [EDGE_W-1:0]    edge_s3;
	logic [PIN_W-1:0]            bits_s3;
	logic signed [ERR_W-1:0]     err_s3;

	// Configuration writes and reads.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PROP:  prop_gain_q  <= pwdata[GAIN_W-1:0];
				REG_INTEG: integ_gain_q <= pwdata[GAIN_W-1:0];
				REG_DERIV: deriv_gain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PROP:  prdata = APB_DATA_W'(prop_gain_q);
			REG_INTEG: prdata = APB_DATA_W'(integ_gain_q);
			REG_DERIV: prdata = APB_DATA_W'(deriv_gain_q);
			default:   prdata = '0;
		endcase
	end

	// Each stage moves when it is empty or the next one moves.
	assign rdy_s3       = !v_s3 || steer.ready;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sensor.ready = rdy_s1;
	assign in_fire      = sensor.valid && rdy_s1;

	// Sensor states, edge flag (highest sensor with an edge wins) and error.
	always_comb begin
		line_now  = ~sensor.raw_pins;
		edge_next = edge_state_q;
		for (int i = 0; i < PIN_W; i++) begin
			if (prev_states_q[i] && !line_now[i]) begin
				edge_next = EDGE_FALL;
			end else if (!prev_states_q[i] && line_now[i]) begin
				edge_next = EDGE_RISE;
			end
		end
		err_now  = position_of(line_now);
		diff_now = DIFF_W'(err_now) - DIFF_W'(prior_error_q);
	end

	// Saturating integral.
	always_comb begin
		sum_wide = (SUM_WIDTH + 1)'(error_sum_q) + (SUM_WIDTH + 1)'(err_now);
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end
	end

	// Controller state advances with every accepted sensor beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_states_q <= '0;
			edge_state_q  <= EDGE_NONE;
			error_sum_q   <= '0;
			prior_error_q <= '0;
		end else if (in_fire) begin
			prev_states_q <= line_now;
			edge_state_q  <= edge_next;
			error_sum_q   <= sum_next;
			prior_error_q <= err_now;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= sensor.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: operand register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_s1 <= sensor.base_speed;
			bits_s1 <= line_now;
			edge_s1 <= edge_next;
			err_s1  <= err_now;
			diff_s1 <= diff_now;
			sum_s1  <= sum_next;
		end
	end

	// Stage 2: the three PID products.
	assign kp_x   = $signed({1'b0, prop_gain_q});
	assign ki_x   = $signed({1'b0, integ_gain_q});
	assign kd_x   = $signed({1'b0, deriv_gain_q});
	assign prod_p = kp_x * err_s1;
	assign prod_i = ki_x * sum_s1;
	assign prod_d = kd_x * diff_s1;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_d_s2 <= prod_d;
			base_s2   <= base_s1;
			bits_s2   <= bits_s1;
			edge_s2   <= edge_s1;
			err_s2    <= err_s1;
		end
	end

	// Stage 3: base plus or minus correction, truncated toward zero and clamped.
	always_comb begin
		base_x = ACC_W'($signed({base_s2, {FRAC_BITS{1'b0}}}));
		corr   = ACC_W'(prod_p_s2) + ACC_W'(prod_i_s2) + ACC_W'(prod_d_s2);
		acc_l  = base_x + corr;
		acc_r  = base_x - corr;
		q_l    = (acc_l + (acc_l[ACC_W-1] ? ACC_W'(TRUNC_BIAS) : ACC_W'(0))) >>> FRAC_BITS;
		q_r    = (acc_r + (acc_r[ACC_W-1] ? ACC_W'(TRUNC_BIAS) : ACC_W'(0))) >>> FRAC_BITS;
		if (q_l > ACC_W'(SPEED_MAX)) begin
			left_c = SPEED_MAX;
		end else if (q_l < ACC_W'(SPEED_MIN)) begin
			left_c = SPEED_MIN;
		end else begin
			left_c = q_l[SPEED_W-1:0];
		end
		if (q_r > ACC_W'(SPEED_MAX)) begin
			right_c = SPEED_MAX;
		end else if (q_r < ACC_W'(SPEED_MIN)) begin
			right_c = SPEED_MIN;
		end else begin
			right_c = q_r[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			left_s3  <= left_c;
			right_s3 <= right_c;
			edge_s3  <= edge_s2;
			bits_s3  <= bits_s2;
			err_s3   <= err_s2;
		end
	end

	// Steering channel.
	assign steer.valid          = v_s3;
	assign steer.left_speed     = left_s3;
	assign steer.right_speed    = right_s3;
	assign steer.edge_mark      = edge_s3;
	assign steer.line_bits      = bits_s3;
	assign steer.position_error = err_s3;

endmodule

>>> rtl/lfps_checker.sv
// Port-level checks of the steering controller and their bind to the top level.
module lfps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [lfps_pkg::SPEED_W-1:0] left_speed,
	input logic signed [lfps_pkg::SPEED_W-1:0] right_speed,
	input logic [lfps_pkg::PIN_W-1:0]         line_bits,
	input logic signed [lfps_pkg::ERR_W-1:0]  position_error
);
	import lfps_pkg::*;

	// A stalled steering beat stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("steering beat dropped while stalled");

	// A stalled steering beat keeps its speeds, line bits and position error.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_speed) && $stable(right_speed)
			&& $stable(line_bits) && $stable(position_error))
		else $error("steering payload changed while stalled");

	// Both motor speeds stay inside the clamp limits.
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_speed <= SPEED_MAX && left_speed >= SPEED_MIN
			&& right_speed <= SPEED_MAX && right_speed >= SPEED_MIN)
		else $error("motor speed outside clamp limits");

	// All weights are odd, so the error parity follows the count of lit sensors.
	a_err_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position_error[0] == ^line_bits)
		else $error("position error does not match line bits");

endmodule

bind line_follower_pid_steering lfps_checker u_lfps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (steer.valid),
	.out_ready      (steer.ready),
	.left_speed     (steer.left_speed),
	.right_speed    (steer.right_speed),
	.line_bits      (steer.line_bits),
	.position_error (steer.position_error)
);

>>> sim/lfps_steer_check.sv
// Scoreboard of the line-follower steering block: predicts every steering beat and compares it.
`timescale 1ns / 1ps

module lfps_steer_check #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lfps_in_if                              sensor,
	lfps_out_if                             steer,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lfps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lfps_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [lfps_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	output int                              failures,
	output int                              pending,
	output int                              beats_checked
);
	import lfps_pkg::*;

	localparam longint SUM_MAX    = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_MIN    = -SUM_MAX - 1;
	localparam longint Q12_ONE    = longint'(1) <<< FRAC_BITS;
	localparam int     PRINT_CAP  = 40;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic signed [EDGE_W-1:0]  edge_mark;
		logic [PIN_W-1:0]          line_bits;
		logic signed [ERR_W-1:0]   position_error;
	} steer_beat_t;

	// Steering beats predicted from accepted sensor beats, oldest first.
	steer_beat_t expected_steer[$];

	// Gains as last written, and the controller state of the predictor.
	logic [GAIN_W-1:0]        prop_gain;
	logic [GAIN_W-1:0]        integ_gain;
	logic [GAIN_W-1:0]        deriv_gain;
	logic [PIN_W-1:0]         last_seen;
	logic signed [EDGE_W-1:0] edge_flag;
	longint                   error_sum;
	int                       prev_err;

	// One line per mismatch, printing stops after a while but counting goes on.
	task automatic report_mismatch(input string what);
		if (failures < PRINT_CAP) begin
			$display("mismatch near steering beat %0d at %0t: %s", beats_checked, $time, what);
		end
		failures++;
	endtask

	function automatic logic signed [SPEED_W-1:0] clamp_speed(input longint v);
		if (v > longint'(SPEED_MAX)) begin
			return SPEED_MAX;
		end
		if (v < longint'(SPEED_MIN)) begin
			return SPEED_MIN;
		end
		return SPEED_W'(v);
	endfunction

	// Advances the controller state by one sensor beat and returns the steering beat.
	function automatic steer_beat_t predict_steer(input logic [PIN_W-1:0] raw,
			input logic signed [SPEED_W-1:0] base);
		logic [PIN_W-1:0] seen;
		steer_beat_t      beat;
		int               i;
		int               err;
		int               slope;
		longint           corr;
		seen = ~raw;
		err  = 0;

		// Scan upward so that the highest sensor with an edge sets the flag.
		for (i = 0; i < PIN_W; i++) begin
			if (last_seen[i] && !seen[i]) begin
				edge_flag = EDGE_FALL;
			end else if (!last_seen[i] && seen[i]) begin
				edge_flag = EDGE_RISE;
			end
		end
		last_seen = seen;

		// Pairs from the outside in weigh 7, 5, 3 and 1; the upper half counts positive.
		for (i = 0; i < PIN_W / 2; i++) begin
			if (seen[PIN_W - 1 - i]) begin
				err += 7 - 2 * i;
			end
			if (seen[i]) begin
				err -= 7 - 2 * i;
			end
		end

		// The integral saturates at the limits of its signed width.
		error_sum = error_sum + err;
		if (error_sum > SUM_MAX) begin
			error_sum = SUM_MAX;
		end
		if (error_sum < SUM_MIN) begin
			error_sum = SUM_MIN;
		end
		slope    = err - prev_err;
		prev_err = err;

		// Correction in Q12; signed division truncates toward zero before the clamp.
		corr = longint'(prop_gain) * err + longint'(integ_gain) * error_sum
			+ longint'(deriv_gain) * slope;
		beat.left_speed     = clamp_speed((longint'(base) * Q12_ONE + corr) / Q12_ONE);
		beat.right_speed    = clamp_speed((longint'(base) * Q12_ONE - corr) / Q12_ONE);
		beat.edge_mark      = edge_flag;
		beat.line_bits      = seen;
		beat.position_error = ERR_W'(err);
		return beat;
	endfunction

	// Register access phase: writes update the gains, reads must return them.
	task automatic track_gain_access();
		logic [REG_IDX_W-1:0] idx;
		logic [GAIN_W-1:0]    held;
		bit                   known;
		idx   = paddr[APB_ADDR_W-1:2];
		held  = '0;
		known = 1'b1;
		case (idx)
			REG_PROP: begin
				held = prop_gain;
			end
			REG_INTEG: begin
				held = integ_gain;
			end
			REG_DERIV: begin
				held = deriv_gain;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		if (pwrite) begin
			case (idx)
				REG_PROP: begin
					prop_gain = pwdata[GAIN_W-1:0];
				end
				REG_INTEG: begin
					integ_gain = pwdata[GAIN_W-1:0];
				end
				REG_DERIV: begin
					deriv_gain = pwdata[GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (known && prdata !== APB_DATA_W'(held)) begin
			report_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h",
				idx, prdata, held));
		end
	endtask

	// Compares one steering beat with the oldest prediction, field by field.
	task automatic compare_steer();
		steer_beat_t want;
		if (expected_steer.size() == 0) begin
			report_mismatch($sformatf("steering beat with nothing expected (left %0d, right %0d)",
				steer.left_speed, steer.right_speed));
			return;
		end
		want = expected_steer.pop_front();
		beats_checked++;
		if (steer.left_speed !== want.left_speed) begin
			report_mismatch($sformatf("left_speed %0d, expected %0d",
				steer.left_speed, want.left_speed));
		end
		if (steer.right_speed !== want.right_speed) begin
			report_mismatch($sformatf("right_speed %0d, expected %0d",
				steer.right_speed, want.right_speed));
		end
		if (steer.edge_mark !== want.edge_mark) begin
			report_mismatch($sformatf("edge_mark %0d, expected %0d",
				steer.edge_mark, want.edge_mark));
		end
		if (steer.line_bits !== want.line_bits) begin
			report_mismatch($sformatf("line_bits 0x%0h, expected 0x%0h",
				steer.line_bits, want.line_bits));
		end
		if (steer.position_error !== want.position_error) begin
			report_mismatch($sformatf("position_error %0d, expected %0d",
				steer.position_error, want.position_error));
		end
	endtask

	// Everything is sampled at the rising edge, before the block's registers move.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain  = PROP_GAIN_RST;
			integ_gain = INTEG_GAIN_RST;
			deriv_gain = DERIV_GAIN_RST;
			last_seen  = '0;
			edge_flag  = EDGE_NONE;
			error_sum  = 0;
			prev_err   = 0;
			expected_steer.delete();
		end else begin
			if (psel && penable && pready) begin
				track_gain_access();
			end
			if (steer.valid && steer.ready) begin
				compare_steer();
			end
			if (sensor.valid && sensor.ready) begin
				expected_steer.push_back(predict_steer(sensor.raw_pins, sensor.base_speed));
			end
		end
		pending = expected_steer.size();
	end

endmodule

>>> sim/tb_line_follower_pid_steering.sv
// Testbench top of the line-follower steering block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_line_follower_pid_steering;
	import lfps_pkg::*;

	// A narrow integral keeps the datapath widths small.
	localparam int SUM_W       = 16;
	localparam int PIPE_CYCLES = 3;
	localparam int HOLD_CYCLES = 40;
	localparam int SWING_RUN   = 24;

	// Index past the last gain register; writes there must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int failures;
	int pending;
	int beats_checked;
	int gain_settings;
	int line_pos;
	int stall_left;
	int n;
	bit gaps_on;
	bit stalls_on;
	bit hold_req;

	lfps_in_if  sensor_ch ();
	lfps_out_if steer_ch ();

	line_follower_pid_steering #(
		.SUM_WIDTH(SUM_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensor  (sensor_ch),
		.steer   (steer_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lfps_steer_check #(
		.SUM_WIDTH(SUM_W)
	) steer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sensor        (sensor_ch),
		.steer         (steer_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.failures      (failures),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	always #6 clk = ~clk;

	// Steering side: random stall bursts, and one long hold-off when asked for.
	initial begin
		steer_ch.ready = 1'b0;
		stall_left     = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_req) begin
					stall_left = HOLD_CYCLES;
					hold_req   = 1'b0;
				end else if (stalls_on && $urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(1, 5);
				end
			end
			if (stall_left != 0) begin
				steer_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				steer_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one sensor beat, maybe after a gap, and returns at the accepting edge.
	task automatic send_reading(input logic [PIN_W-1:0] pins,
			input logic signed [SPEED_W-1:0] base);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
		end
		@(negedge clk);
		if (gap != 0) begin
			sensor_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor_ch.valid      <= 1'b1;
		sensor_ch.raw_pins   <= pins;
		sensor_ch.base_speed <= base;
		do begin
			@(posedge clk);
		end while (!sensor_ch.ready);
	endtask

	// Stops offering and waits until every predicted steering beat has come out.
	task automatic drain();
		@(negedge clk);
		sensor_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (PIPE_CYCLES + 2) @(negedge clk);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input bit is_write,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_gains();
		apb_access(REG_PROP, 1'b0, '0);
		apb_access(REG_INTEG, 1'b0, '0);
		apb_access(REG_DERIV, 1'b0, '0);
	endtask

	task automatic set_gains(input logic [APB_DATA_W-1:0] prop,
			input logic [APB_DATA_W-1:0] integ, input logic [APB_DATA_W-1:0] deriv);
		drain();
		apb_access(REG_PROP, 1'b1, prop);
		apb_access(REG_INTEG, 1'b1, integ);
		apb_access(REG_DERIV, 1'b1, deriv);
		gain_settings++;
	endtask

	// Mostly a line drifting under the array, with crossings, lost line and noise mixed in.
	task automatic send_random_reading();
		logic [PIN_W-1:0]          seen;
		logic signed [SPEED_W-1:0] base;
		int                        pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// Even positions sit on one sensor, odd ones straddle two neighbors.
			line_pos += int'($urandom_range(0, 2)) - 1;
			if (line_pos < 0) begin
				line_pos = 0;
			end
			if (line_pos > 2 * PIN_W - 2) begin
				line_pos = 2 * PIN_W - 2;
			end
			seen = PIN_W'(1) << (line_pos / 2);
			if (line_pos % 2 == 1) begin
				seen = seen | (seen << 1);
			end
		end else if (pick < 72) begin
			seen = ($urandom_range(0, 1) != 0) ? '0 : '1;
		end else begin
			seen = PIN_W'($urandom);
		end
		if ($urandom_range(0, 4) == 0) begin
			base = SPEED_W'($urandom);
		end else begin
			base = SPEED_W'(int'($urandom_range(0, 200)) - 100);
		end
		send_reading(~seen, base);
	endtask

	// Random beats with idling switched on and off in stretches of 25.
	task automatic run_random(input int count, input int hold_at, input int pause_at);
		int k;
		for (k = 0; k < count; k++) begin
			if (k % 25 == 0) begin
				gaps_on   = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			if (k == hold_at) begin
				gaps_on  = 1'b0;
				hold_req = 1'b1;
			end
			if (k == pause_at) begin
				drain();
			end
			send_random_reading();
		end
	endtask

	// Run limit, far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		sensor_ch.valid      = 1'b0;
		sensor_ch.raw_pins   = '1;
		sensor_ch.base_speed = '0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		gaps_on              = 1'b0;
		stalls_on            = 1'b0;
		hold_req             = 1'b0;
		line_pos             = PIN_W - 1;
		gain_settings        = 1;
		arst_n               = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default gains read back, then directed beats under them.
		read_gains();
		send_reading(8'hFF, 8'sd0);      // no line, no edge yet
		send_reading(8'hFF, 8'sd100);
		send_reading(8'h00, -8'sd100);   // every sensor turns on at once
		send_reading(8'hFF, 8'sd127);    // every sensor turns off, base past the limit
		send_reading(8'hFF, 8'sh80);     // no edge keeps the flag
		send_reading(8'hFE, 8'sd50);     // outermost low sensor alone
		send_reading(8'h7F, -8'sd50);    // ends swap: the high sensor decides
		send_reading(8'hFE, 8'sd0);
		send_reading(8'h0F, 8'sd100);    // largest positive error
		send_reading(8'hF0, 8'sd100);    // largest negative error, biggest step
		send_reading(8'hF0, -8'sd100);
		send_reading(8'h0F, -8'sd100);
		send_reading(8'hE7, 8'sd30);     // centered
		send_reading(8'hAA, -8'sd1);
		send_reading(8'h55, 8'sd1);
		send_reading(8'hFF, 8'sh80);

		// Largest gains; upper data bits must be dropped and the spare index ignored.
		set_gains(32'hA5A5_FFFF, 32'h5A5A_FFFF, 32'hFFFF_FFFF);
		apb_access(REG_SPARE, 1'b1, 32'h0000_1234);
		read_gains();
		run_random(90, -1, -1);

		// Zero gains: the speeds follow the base alone.
		set_gains(32'd0, 32'd0, 32'd0);
		run_random(50, -1, -1);

		// Random gains, with one long hold-off on the steering side.
		set_gains(32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
			32'($urandom_range(0, 65535)));
		run_random(130, 20, -1);

		// Smaller gains; one full pause midway.
		set_gains(32'($urandom_range(0, 8192)), 32'($urandom_range(0, 128)),
			32'($urandom_range(0, 4096)));
		run_random(120, -1, 60);

		// Error held at one extreme and then the other, at full rate.
		set_gains(32'd4096, 32'd1, 32'd2048);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		for (n = 0; n < 2 * SWING_RUN; n++) begin
			send_reading((n < SWING_RUN) ? 8'h0F : 8'hF0,
				SPEED_W'(int'($urandom_range(0, 200)) - 100));
		end
		drain();

		$display("summary: %0d steering beats checked under %0d gain settings", beats_checked,
			gain_settings);
		$display("summary: edge cases, error extremes, long stalls and full-rate swings covered");
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
